// ----- hw/rtl/sss_pkg.sv -----
// Shared types and constants for the packed slot script store.
package sss_pkg;

   // Upload packet layout (byte positions from the packet start)
   localparam int POS_OPCODE  = 0;
   localparam int POS_SLOT    = 4;
   localparam int POS_SIZE_LO = 5;
   localparam int POS_SIZE_HI = 6;
   localparam int POS_OFS_LO  = 7;
   localparam int POS_OFS_HI  = 8;
   localparam int POS_DATA    = 9;

   localparam logic [7:0] UPLOAD_OPCODE = 8'h0d;

   typedef enum logic [1:0] {
      OP_UPLOAD  = 2'd0,
      OP_COMPACT = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_UPLOAD  = 2'd0,
      KIND_COMPACT = 2'd1,
      KIND_READ    = 2'd2
   } kind_type;

   // Source of a byte store write issued in the cycle before
   typedef enum logic [1:0] {
      WSRC_STORE = 2'd0,
      WSRC_CHUNK = 2'd1,
      WSRC_ZERO  = 2'd2
   } wsrc_type;

endpackage

// ----- hw/rtl/sss_ram.sv -----
// Single write port, single registered read port RAM.
module sss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/packed_slot_script_store_core.sv -----
// Top level: packed slot script store with its byte-move sequencer.
//
//  channel  | ports                                    | transfer
//  ---------+------------------------------------------+------------------------------
//  request  | start, busy, req_*                       | edge with start=1, busy=0
//  response | rsp_valid, rsp_*                         | edge ending the rsp_valid cycle
//
// Sequencing: a non-final upload byte leaves busy low. A final byte runs a header
// check and a slot table scan; a first chunk then gets a byte shift (bytes above the
// gap, one per cycle) and a table update; every chunk ends with the chunk copy (one
// byte per cycle). Compaction checks each slot in turn and, per removed slot, moves
// the bytes above it down and zeroes the freed bytes, one per cycle, then updates
// the slot table. A read looks up the slot, then fetches the byte. The single byte
// store port sets these rates. Reset: a clearing pass zeroes the store; busy is
// high during it. The receiver cannot stall: each response shows for one cycle.
module packed_slot_script_store_core #(
   parameter int SLOTS        = 16,
   parameter int STORE_BYTES  = 1024,
   parameter int CHUNK_BYTES  = 55,
   parameter int PACKET_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last,
   input  logic [15:0] req_empty_mask,
   input  logic [3:0]  req_read_slot,
   input  logic [9:0]  req_read_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic        rsp_ok,
   output logic        rsp_slot_finished,
   output logic        rsp_position_clear,
   output logic [3:0]  rsp_slot,
   output logic [10:0] rsp_script_size,
   output logic [7:0]  rsp_data_byte
);
   import sss_pkg::*;

   localparam int AW = $clog2(STORE_BYTES + 1);   // byte counts and offsets
   localparam int MW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int KW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int TW = $clog2(CHUNK_BYTES + 1);
   localparam int PW = $clog2(PACKET_BYTES + 2);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_UP_CHK, S_UP_SCAN, S_UP_DEC, S_SHIFT, S_ALLOC, S_CHUNK,
      S_UP_RESP, S_CP_CHK, S_CP_MOVE, S_CP_ZERO, S_CP_ADJ, S_RD_LOOK, S_RD_DATA
   } state_type;

   state_type state_ff, state_in;

   // slot table
   logic [AW-1:0] off_ff [SLOTS];
   logic [AW-1:0] off_in [SLOTS];
   logic [AW-1:0] len_ff [SLOTS];
   logic [AW-1:0] len_in [SLOTS];
   logic [SLOTS-1:0] use_ff, use_in;
   logic [AW-1:0] bu_ff, bu_in;

   // packet capture
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]  hdr_op_ff, hdr_op_in;
   logic [7:0]  hdr_slot_ff, hdr_slot_in;
   logic [15:0] hdr_size_ff, hdr_size_in;
   logic [15:0] hdr_co_ff, hdr_co_in;
   logic        len_ok_ff, len_ok_in;

   // sequencer working registers
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] cs_ff, cs_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] gap_ff, gap_in;
   logic [AW-1:0] off_r_ff, off_r_in;
   logic [AW-1:0] len_r_ff, len_r_in;
   logic          use_r_ff, use_r_in;
   logic [AW-1:0] cb_ff, cb_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] take_ff, take_in;
   logic          fin_ff, fin_in;
   logic          alloc_ff, alloc_in;
   logic [15:0]   mask_ff, mask_in;
   logic [9:0]    ix_ff, ix_in;

   // pending store write (data arrives from a read issued the cycle before)
   logic          pw_valid_ff, pw_valid_in;
   logic [MW-1:0] pw_addr_ff, pw_addr_in;
   wsrc_type      pw_src_ff, pw_src_in;

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_fin_ff, rsp_fin_in;
   logic        rsp_pc_ff, rsp_pc_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [10:0] rsp_size_ff, rsp_size_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   // memory ports
   logic          st_rd_en;
   logic [MW-1:0] st_rd_addr;
   logic [7:0]    st_rd_data;
   logic [7:0]    st_wr_data;
   logic          ck_wr_en;
   logic [CW-1:0] ck_wr_addr;
   logic          ck_rd_en;
   logic [CW-1:0] ck_rd_addr;
   logic [7:0]    ck_rd_data;

   // helpers
   logic [KW-1:0] sidx;
   logic [AW-1:0] szw;
   logic [PW-1:0] pos_next;
   logic [15:0]   left;
   logic [AW-1:0] src;

   assign sidx = KW'(hdr_slot_ff);
   assign szw  = AW'(hdr_size_ff);
   assign left = hdr_size_ff - hdr_co_ff;
   assign src  = i_ff - AW'(1);
   assign pos_next = (32'(pos_ff) < PACKET_BYTES + 1) ? pos_ff + PW'(1) : pos_ff;

   always_comb begin
      case (pw_src_ff)
         WSRC_STORE: st_wr_data = st_rd_data;
         WSRC_CHUNK: st_wr_data = ck_rd_data;
         default:    st_wr_data = 8'd0;
      endcase
   end

   sss_ram #(.WIDTH(8), .DEPTH(STORE_BYTES), .ADDR_W(MW)) u_store (
      .clock   (clock),
      .wr_en   (pw_valid_ff),
      .wr_addr (pw_addr_ff),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   sss_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES), .ADDR_W(CW)) u_chunk (
      .clock   (clock),
      .wr_en   (ck_wr_en),
      .wr_addr (ck_wr_addr),
      .wr_data (req_packet_byte),
      .rd_en   (ck_rd_en),
      .rd_addr (ck_rd_addr),
      .rd_data (ck_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      off_in = off_ff;
      len_in = len_ff;
      use_in = use_ff;
      bu_in = bu_ff;
      pos_in = pos_ff;
      hdr_op_in = hdr_op_ff;
      hdr_slot_in = hdr_slot_ff;
      hdr_size_in = hdr_size_ff;
      hdr_co_in = hdr_co_ff;
      len_ok_in = len_ok_ff;
      k_in = k_ff;
      cs_in = cs_ff;
      i_in = i_ff;
      gap_in = gap_ff;
      off_r_in = off_r_ff;
      len_r_in = len_r_ff;
      use_r_in = use_r_ff;
      cb_in = cb_ff;
      cnt_in = cnt_ff;
      take_in = take_ff;
      fin_in = fin_ff;
      alloc_in = alloc_ff;
      mask_in = mask_ff;
      ix_in = ix_ff;
      pw_valid_in = 1'b0;
      pw_addr_in = pw_addr_ff;
      pw_src_in = pw_src_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_ok_in = rsp_ok_ff;
      rsp_fin_in = rsp_fin_ff;
      rsp_pc_in = rsp_pc_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_size_in = rsp_size_ff;
      rsp_data_in = rsp_data_ff;
      st_rd_en = 1'b0;
      st_rd_addr = '0;
      ck_wr_en = 1'b0;
      ck_wr_addr = '0;
      ck_rd_en = 1'b0;
      ck_rd_addr = '0;

      case (state_ff)
         S_CLR: begin
            pw_valid_in = 1'b1;
            pw_addr_in = MW'(i_ff);
            pw_src_in = WSRC_ZERO;
            if (32'(i_ff) == STORE_BYTES - 1) begin
               state_in = S_IDLE;
            end else begin
               i_in = i_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               case (op_type'(req_op))
                  OP_UPLOAD: begin
                     if (32'(pos_ff) == POS_OPCODE) hdr_op_in = req_packet_byte;
                     if (32'(pos_ff) == POS_SLOT) hdr_slot_in = req_packet_byte;
                     if (32'(pos_ff) == POS_SIZE_LO) hdr_size_in[7:0] = req_packet_byte;
                     if (32'(pos_ff) == POS_SIZE_HI) hdr_size_in[15:8] = req_packet_byte;
                     if (32'(pos_ff) == POS_OFS_LO) hdr_co_in[7:0] = req_packet_byte;
                     if (32'(pos_ff) == POS_OFS_HI) hdr_co_in[15:8] = req_packet_byte;
                     if (32'(pos_ff) >= POS_DATA &&
                         32'(pos_ff) - POS_DATA < CHUNK_BYTES) begin
                        ck_wr_en = 1'b1;
                        ck_wr_addr = CW'(32'(pos_ff) - POS_DATA);
                     end
                     if (req_last) begin
                        len_ok_in = (32'(pos_next) == PACKET_BYTES);
                        pos_in = '0;
                        state_in = S_UP_CHK;
                     end else begin
                        pos_in = pos_next;
                     end
                  end
                  OP_COMPACT: begin
                     mask_in = req_empty_mask;
                     cs_in = '0;
                     k_in = '0;
                     state_in = S_CP_CHK;
                  end
                  OP_READ: begin
                     rsp_kind_in = KIND_READ;
                     rsp_ok_in = 1'b0;
                     rsp_fin_in = 1'b0;
                     rsp_pc_in = 1'b0;
                     rsp_slot_in = req_read_slot;
                     rsp_size_in = '0;
                     rsp_data_in = '0;
                     ix_in = req_read_index;
                     if (32'(req_read_slot) < SLOTS) begin
                        k_in = KW'(req_read_slot);
                        state_in = S_RD_LOOK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_UP_CHK: begin
            rsp_kind_in = KIND_UPLOAD;
            rsp_ok_in = 1'b0;
            rsp_fin_in = 1'b0;
            rsp_pc_in = 1'b0;
            rsp_slot_in = hdr_slot_ff[3:0];
            rsp_size_in = '0;
            rsp_data_in = '0;
            if (len_ok_ff && hdr_op_ff == UPLOAD_OPCODE && 32'(hdr_slot_ff) < SLOTS &&
                32'(hdr_size_ff) <= STORE_BYTES) begin
               k_in = '0;
               gap_in = '0;
               state_in = S_UP_SCAN;
            end else begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         // find the end of the last allocated lower slot, fetch the slot's entry
         S_UP_SCAN: begin
            if (k_ff < sidx && use_ff[k_ff]) gap_in = off_ff[k_ff] + len_ff[k_ff];
            if (k_ff == sidx) begin
               use_r_in = use_ff[k_ff];
               off_r_in = off_ff[k_ff];
               len_r_in = len_ff[k_ff];
            end
            if (32'(k_ff) == SLOTS - 1) begin
               state_in = S_UP_DEC;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         S_UP_DEC: begin
            take_in = (32'(left) < CHUNK_BYTES) ? TW'(left) : TW'(CHUNK_BYTES);
            fin_in = (32'(left) <= CHUNK_BYTES);
            cnt_in = '0;
            k_in = '0;
            if (hdr_co_ff == 16'd0) begin
               alloc_in = 1'b1;
               cb_in = gap_ff;
               i_in = bu_ff;
               if (use_r_ff || 32'(hdr_size_ff) > STORE_BYTES - 32'(bu_ff)) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (hdr_size_ff != 16'd0 && bu_ff > gap_ff) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_ALLOC;
               end
            end else begin
               alloc_in = 1'b0;
               cb_in = AW'(32'(off_r_ff) + 32'(hdr_co_ff));
               if (!use_r_ff || 32'(len_r_ff) != 32'(hdr_size_ff) ||
                   hdr_co_ff >= hdr_size_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_CHUNK;
               end
            end
         end

         // open the gap: move bytes up by the new size, top byte first
         S_SHIFT: begin
            st_rd_en = 1'b1;
            st_rd_addr = MW'(src);
            pw_valid_in = 1'b1;
            pw_addr_in = MW'(src + szw);
            pw_src_in = WSRC_STORE;
            i_in = src;
            if (src == gap_ff) state_in = S_ALLOC;
         end

         S_ALLOC: begin
            if (k_ff == sidx) begin
               off_in[k_ff] = gap_ff;
               len_in[k_ff] = szw;
               use_in[k_ff] = 1'b1;
            end else if (k_ff > sidx && use_ff[k_ff]) begin
               off_in[k_ff] = off_ff[k_ff] + szw;
            end
            if (32'(k_ff) == SLOTS - 1) begin
               bu_in = bu_ff + szw;
               state_in = S_CHUNK;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         S_CHUNK: begin
            if (cnt_ff == take_ff) begin
               state_in = S_UP_RESP;
            end else begin
               ck_rd_en = 1'b1;
               ck_rd_addr = CW'(cnt_ff);
               pw_valid_in = 1'b1;
               pw_addr_in = MW'(cb_ff + AW'(cnt_ff));
               pw_src_in = (32'(cnt_ff) + POS_DATA < PACKET_BYTES) ? WSRC_CHUNK : WSRC_ZERO;
               cnt_in = cnt_ff + TW'(1);
            end
         end

         S_UP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in = 1'b1;
            rsp_fin_in = fin_ff;
            rsp_pc_in = alloc_ff;
            state_in = S_IDLE;
         end

         S_CP_CHK: begin
            if (use_ff[k_ff] && mask_ff[k_ff]) begin
               off_r_in = off_ff[k_ff];
               len_r_in = len_ff[k_ff];
               i_in = off_ff[k_ff] + len_ff[k_ff];
               state_in = S_CP_MOVE;
            end else if (32'(cs_ff) == SLOTS - 1) begin
               rsp_kind_in = KIND_COMPACT;
               rsp_ok_in = 1'b0;
               rsp_fin_in = 1'b0;
               rsp_pc_in = 1'b0;
               rsp_slot_in = '0;
               rsp_size_in = '0;
               rsp_data_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cs_in = cs_ff + KW'(1);
               k_in = cs_ff + KW'(1);
            end
         end

         // close the gap: move bytes down by the freed length
         S_CP_MOVE: begin
            if (len_r_ff != '0 && i_ff < bu_ff) begin
               st_rd_en = 1'b1;
               st_rd_addr = MW'(i_ff);
               pw_valid_in = 1'b1;
               pw_addr_in = MW'(i_ff - len_r_ff);
               pw_src_in = WSRC_STORE;
               i_in = i_ff + AW'(1);
            end else begin
               i_in = bu_ff - len_r_ff;
               state_in = S_CP_ZERO;
            end
         end

         S_CP_ZERO: begin
            if (i_ff < bu_ff) begin
               pw_valid_in = 1'b1;
               pw_addr_in = MW'(i_ff);
               pw_src_in = WSRC_ZERO;
               i_in = i_ff + AW'(1);
            end else begin
               bu_in = bu_ff - len_r_ff;
               k_in = '0;
               state_in = S_CP_ADJ;
            end
         end

         S_CP_ADJ: begin
            if (k_ff == cs_ff) begin
               off_in[k_ff] = '0;
               len_in[k_ff] = '0;
               use_in[k_ff] = 1'b0;
            end else if (use_ff[k_ff] && off_ff[k_ff] > off_r_ff) begin
               off_in[k_ff] = off_ff[k_ff] - len_r_ff;
            end
            if (32'(k_ff) == SLOTS - 1) begin
               k_in = cs_ff;
               state_in = S_CP_CHK;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         S_RD_LOOK: begin
            if (use_ff[k_ff]) begin
               rsp_size_in = 11'(len_ff[k_ff]);
               if (32'(ix_ff) < 32'(len_ff[k_ff])) begin
                  rsp_ok_in = 1'b1;
                  st_rd_en = 1'b1;
                  st_rd_addr = MW'(off_ff[k_ff] + AW'(ix_ff));
                  state_in = S_RD_DATA;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_RD_DATA: begin
            rsp_data_in = st_rd_data;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         i_ff <= '0;
         use_ff <= '0;
         bu_ff <= '0;
         pos_ff <= '0;
         hdr_op_ff <= '0;
         hdr_slot_ff <= '0;
         hdr_size_ff <= '0;
         hdr_co_ff <= '0;
         pw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < SLOTS; n++) begin
            off_ff[n] <= '0;
            len_ff[n] <= '0;
         end
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         use_ff <= use_in;
         bu_ff <= bu_in;
         pos_ff <= pos_in;
         hdr_op_ff <= hdr_op_in;
         hdr_slot_ff <= hdr_slot_in;
         hdr_size_ff <= hdr_size_in;
         hdr_co_ff <= hdr_co_in;
         pw_valid_ff <= pw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         off_ff <= off_in;
         len_ff <= len_in;
      end
      len_ok_ff <= len_ok_in;
      k_ff <= k_in;
      cs_ff <= cs_in;
      gap_ff <= gap_in;
      off_r_ff <= off_r_in;
      len_r_ff <= len_r_in;
      use_r_ff <= use_r_in;
      cb_ff <= cb_in;
      cnt_ff <= cnt_in;
      take_ff <= take_in;
      fin_ff <= fin_in;
      alloc_ff <= alloc_in;
      mask_ff <= mask_in;
      ix_ff <= ix_in;
      pw_addr_ff <= pw_addr_in;
      pw_src_ff <= pw_src_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_fin_ff <= rsp_fin_in;
      rsp_pc_ff <= rsp_pc_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_size_ff <= rsp_size_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_slot_finished = rsp_fin_ff;
   assign rsp_position_clear = rsp_pc_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_script_size = rsp_size_ff;
   assign rsp_data_byte = rsp_data_ff;

endmodule
